// ===== src/lps_pkg.sv =====
// ---------------------------------------------------------------------------
// lps_pkg: shared types and constants of the status LED pattern sequencer
// Word layouts, configuration register indexes, pattern encodings and the
// pattern lookup functions.
// ---------------------------------------------------------------------------
package lps_pkg;

    // Countdown width and the width of the period registers.
    localparam int CNT_W    = 16;
    localparam int PERIOD_W = 16;
    localparam int LOAD_W   = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RARE_ON_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RARE_OFF_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RGB_VARIANT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_ENABLE  = 3'd6;

    // Pattern modes (low three bits of a pattern).
    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_BREATH = 3'd1;
    localparam logic [2:0] MODE_NORMAL = 3'd2;
    localparam logic [2:0] MODE_RARE   = 3'd3;
    localparam logic [2:0] MODE_FAST   = 3'd4;
    localparam logic [2:0] MODE_ALT    = 3'd5;

    // System codes.
    localparam logic [2:0] SYS_IDLE   = 3'd0;
    localparam logic [2:0] SYS_BOOT   = 3'd1;
    localparam logic [2:0] SYS_JOIN   = 3'd2;
    localparam logic [2:0] SYS_SAMPLE = 3'd3;
    localparam logic [2:0] SYS_SEND   = 3'd4;
    localparam logic [2:0] SYS_REBOOT = 3'd5;

    // Battery codes.
    localparam logic [1:0] BATT_OK       = 2'd0;
    localparam logic [1:0] BATT_LOW      = 2'd1;
    localparam logic [1:0] BATT_CHARGING = 2'd2;
    localparam logic [1:0] BATT_CHARGED  = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [2:0] system_state;
        logic       charging;
        logic       vbus_present;
        logic       battery_low;
    } t_in_word;

    typedef struct packed {
        logic red_on;
        logic green_on;
        logic blue_on;
        logic breath_select;
        logic blink_timer_run;
        logic keep_awake;
    } t_out_word;

    typedef struct packed {
        logic [PERIOD_W-1:0] normal_period;
        logic [PERIOD_W-1:0] fast_period;
        logic [PERIOD_W-1:0] rare_on_period;
        logic [PERIOD_W-1:0] rare_off_period;
        logic [PERIOD_W-1:0] refresh_period;
        logic                rgb_variant;
        logic                battery_enable;
    } t_cfg;

    // A pattern: lamp enables above the mode.
    typedef struct packed {
        logic       blue;
        logic       green;
        logic       red;
        logic [2:0] mode;
    } t_pattern;

    localparam t_pattern PAT_OFF = '{blue: 1'b0, green: 1'b0, red: 1'b0, mode: MODE_OFF};

    function automatic t_pattern sys_pattern(input logic [2:0] code, input logic rgb);
        t_pattern p;
        p = PAT_OFF;
        case (code)
            SYS_BOOT: begin
                if (rgb) begin
                    p.blue = 1'b1;
                end else begin
                    p.red   = 1'b1;
                    p.green = 1'b1;
                end
                p.mode = MODE_NORMAL;
            end
            SYS_JOIN: begin
                p.red  = 1'b1;
                p.mode = MODE_NORMAL;
            end
            SYS_SAMPLE: begin
                p.red   = 1'b1;
                p.green = 1'b1;
                p.mode  = MODE_ALT;
            end
            SYS_SEND: begin
                p.green = 1'b1;
                p.mode  = MODE_NORMAL;
            end
            SYS_REBOOT: begin
                p.red  = 1'b1;
                p.mode = MODE_FAST;
            end
            default: begin
                p = PAT_OFF;
            end
        endcase
        return p;
    endfunction

    function automatic t_pattern batt_pattern(input logic [1:0] code);
        t_pattern p;
        p = PAT_OFF;
        case (code)
            BATT_LOW: begin
                p.red  = 1'b1;
                p.mode = MODE_RARE;
            end
            BATT_CHARGING: begin
                p.red  = 1'b1;
                p.mode = MODE_BREATH;
            end
            BATT_CHARGED: begin
                p.green = 1'b1;
                p.mode  = MODE_BREATH;
            end
            default: begin
                p = PAT_OFF;
            end
        endcase
        return p;
    endfunction

    // Idle picks from the battery table, any other system code from the system table.
    function automatic t_pattern choose_pattern(input logic [2:0] sys, input logic [1:0] batt,
                                                input logic rgb);
        return (sys != SYS_IDLE) ? sys_pattern(sys, rgb) : batt_pattern(batt);
    endfunction

endpackage

// ===== src/lps_cfg.sv =====
// ---------------------------------------------------------------------------
// lps_cfg: configuration register file
// Holds the periods and option bits; unknown indexes are ignored.
// ---------------------------------------------------------------------------
module lps_cfg
    import lps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_wr_index,
    input  logic [PERIOD_W-1:0]  i_wr_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                CFG_NORMAL_PERIOD:   n_cfg.normal_period   = i_wr_data;
                CFG_FAST_PERIOD:     n_cfg.fast_period     = i_wr_data;
                CFG_RARE_ON_PERIOD:  n_cfg.rare_on_period  = i_wr_data;
                CFG_RARE_OFF_PERIOD: n_cfg.rare_off_period = i_wr_data;
                CFG_REFRESH_PERIOD:  n_cfg.refresh_period  = i_wr_data;
                CFG_RGB_VARIANT:     n_cfg.rgb_variant     = i_wr_data[0];
                CFG_BATTERY_ENABLE:  n_cfg.battery_enable  = i_wr_data[0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_period   <= PERIOD_W'(250);
            r_cfg.fast_period     <= PERIOD_W'(50);
            r_cfg.rare_on_period  <= PERIOD_W'(50);
            r_cfg.rare_off_period <= PERIOD_W'(4000);
            r_cfg.refresh_period  <= PERIOD_W'(10000);
            r_cfg.rgb_variant     <= 1'b1;
            r_cfg.battery_enable  <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/lps_core.sv =====
// ---------------------------------------------------------------------------
// lps_core: sequencer state and combinational update logic
// Holds system code, battery code, pattern, blink phase and countdown, and
// computes the lamp word that one input word leaves behind.
// ---------------------------------------------------------------------------
module lps_core
    import lps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_word
);

    logic [2:0]       r_sys, n_sys;
    logic [1:0]       r_batt, n_batt;
    t_pattern         r_pat, n_pat;
    logic             r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_armed, n_armed;

    logic                is_notify;
    logic                upd_notify;
    logic                upd_tick;
    t_pattern            p_notify;
    t_pattern            pat0;
    t_pattern            pat_resample;
    logic [2:0]          sys_eff;
    logic [1:0]          batt_s;
    logic                batt_same;
    logic                changed;
    logic [PERIOD_W-1:0] delay;
    logic [LOAD_W-1:0]   delay_w;
    logic [LOAD_W-1:0]   top_w;
    logic                alt;

    always_comb begin
        is_notify  = i_word.operation;
        p_notify   = choose_pattern(i_word.system_state, r_batt, i_cfg.rgb_variant);
        upd_notify = is_notify && (i_word.system_state != r_sys) && (p_notify != r_pat);
        upd_tick   = !is_notify && r_armed && (r_cnt <= CNT_W'(1));
        sys_eff    = is_notify ? i_word.system_state : r_sys;
        pat0       = upd_notify ? p_notify : r_pat;

        // Battery sample, priority charging, then supply, then low.
        batt_s = BATT_OK;
        if (i_cfg.battery_enable) begin
            if (i_word.charging) begin
                batt_s = BATT_CHARGING;
            end else if (i_word.vbus_present) begin
                batt_s = BATT_CHARGED;
            end else if (i_word.battery_low) begin
                batt_s = BATT_LOW;
            end
        end
        batt_same    = i_cfg.battery_enable && (batt_s == r_batt);
        pat_resample = batt_same ? pat0 : choose_pattern(sys_eff, batt_s, i_cfg.rgb_variant);
        changed      = upd_notify || (pat_resample != pat0);

        n_sys   = r_sys;
        n_batt  = r_batt;
        n_pat   = r_pat;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_armed = r_armed;
        delay   = i_cfg.refresh_period;

        case (pat_resample.mode)
            MODE_OFF:    delay = i_cfg.refresh_period;
            MODE_BREATH: delay = i_cfg.refresh_period;
            MODE_NORMAL: delay = i_cfg.normal_period;
            MODE_ALT:    delay = i_cfg.normal_period;
            MODE_FAST:   delay = i_cfg.fast_period;
            MODE_RARE:   delay = (changed || !r_phase) ? i_cfg.rare_on_period
                                                       : i_cfg.rare_off_period;
            default:     delay = i_cfg.refresh_period;
        endcase

        // Zero loads as one tick; a period wider than the countdown saturates.
        delay_w = LOAD_W'(delay);
        top_w   = LOAD_W'({CNT_W{1'b1}});
        if (delay_w == '0) begin
            delay_w = LOAD_W'(1);
        end else if (delay_w > top_w) begin
            delay_w = top_w;
        end

        if (i_step) begin
            if (is_notify) begin
                n_sys = i_word.system_state;
            end
            if (upd_notify || upd_tick) begin
                n_batt  = batt_s;
                n_pat   = pat_resample;
                n_cnt   = CNT_W'(delay_w);
                n_armed = 1'b1;
                if (pat_resample.mode == MODE_OFF) begin
                    n_phase = 1'b0;
                end else if (pat_resample.mode == MODE_BREATH) begin
                    n_phase = 1'b1;
                end else begin
                    n_phase = changed || !r_phase;
                end
            end else if (!is_notify && r_armed) begin
                n_cnt = r_cnt - CNT_W'(1);
            end
        end

        // The result word shows the state after this word.
        alt                    = (n_pat.mode == MODE_ALT);
        o_word.red_on          = (n_phase ^ alt) && n_pat.red;
        o_word.green_on        = n_phase && n_pat.green;
        o_word.blue_on         = i_cfg.rgb_variant && n_phase && n_pat.blue;
        o_word.breath_select   = (n_pat.mode == MODE_BREATH);
        o_word.blink_timer_run = (n_pat.mode >= MODE_NORMAL);
        o_word.keep_awake      = n_phase || alt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys   <= SYS_IDLE;
            r_batt  <= BATT_OK;
            r_pat   <= PAT_OFF;
            r_phase <= 1'b0;
            r_cnt   <= '0;
            r_armed <= 1'b0;
        end else begin
            r_sys   <= n_sys;
            r_batt  <= n_batt;
            r_pat   <= n_pat;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_armed <= n_armed;
        end
    end

endmodule

// ===== src/status_led_pattern_sequencer_top.sv =====
// ---------------------------------------------------------------------------
// status_led_pattern_sequencer_top: status LED pattern sequencer
// Turns timer ticks and system state notifications into lamp enables.
//
//   Channel | Direction | Handshake                  | Word
//   --------+-----------+----------------------------+---------------------
//   in      | input     | i_in_valid / o_in_ready    | i_in_word  (t_in_word)
//   out     | output    | o_out_valid / i_out_ready  | o_out_word (t_out_word)
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Every input word produces exactly one output word. The word waits in the
// input register until the core processes it, and its result then waits in
// the result register until the output takes it.
// One word is accepted every cycle while the output does not stall; the rate is
// set by the combinational update path in the core between the input and result registers.
// Reset is synchronous and active low; it restores every register default,
// clears the sequencer state and empties both pipeline registers.
// A stalled output holds its word; the input register keeps accepting while it is
// empty or its word can move into the result register in the same cycle.
// ---------------------------------------------------------------------------
module status_led_pattern_sequencer_top
    import lps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PERIOD_W-1:0]  i_cfg_data
);

    t_cfg      cfg;
    t_out_word core_word;

    logic      r_in_vld;
    t_in_word  r_in;
    logic      r_out_vld;
    t_out_word r_out;
    logic      step;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    lps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The registered input word is processed when the result register is
    // free or is being emptied in this cycle.
    assign step       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || step;

    lps_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (r_in),
        .i_cfg   (cfg),
        .o_word  (core_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_word;
        end
        if (step) begin
            r_out <= core_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // A processed word always lands in the result register.
    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_vld)
        else $error("processed word did not reach the result register");

    // A held input word with a stalled output blocks new input.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while the pipeline is full");

    // Breathing and blinking are exclusive modes.
    a_mode_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.breath_select && o_out_word.blink_timer_run))
        else $error("breath and blink selected together");

    // Any lit lamp keeps the system awake.
    a_lit_awake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.red_on || o_out_word.green_on || o_out_word.blue_on))
        |-> o_out_word.keep_awake)
        else $error("lamp lit without keep_awake");

endmodule

// ===== test/tb_status_led_pattern_sequencer_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_status_led_pattern_sequencer_top: self-checking bench for the LED sequencer
// A driver feeds tick and notify words from a queue in random bursts. A
// monitor compares every output word with the word computed by a local model
// of the sequencer. The register settings change between phases while the
// block is empty.
// ---------------------------------------------------------------------------
module tb_status_led_pattern_sequencer_top;
    import lps_pkg::*;

    // Operation codes carried in the operation field of an input word.
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_NOTIFY = 1'b1;

    // Index beyond the register file; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    // Cycles to let pass once the block looks empty (two pipeline stages).
    localparam int DRAIN_CYCLES = 4;

    // Clock and reset.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Ports of the block; the inputs are all at known values from time zero.
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_word             i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_word            o_out_word;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [PERIOD_W-1:0]  i_cfg_data  = '0;

    status_led_pattern_sequencer_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Words waiting to be offered, and lamp words waiting to be seen.
    t_in_word  pending_words[$];
    t_out_word expected_lamps[$];

    // Local copy of the register file, starting at the reset defaults.
    logic [PERIOD_W-1:0] cf_normal   = 16'd250;
    logic [PERIOD_W-1:0] cf_fast     = 16'd50;
    logic [PERIOD_W-1:0] cf_rare_on  = 16'd50;
    logic [PERIOD_W-1:0] cf_rare_off = 16'd4000;
    logic [PERIOD_W-1:0] cf_refresh  = 16'd10000;
    logic                cf_rgb      = 1'b1;
    logic                cf_batt_en  = 1'b1;

    // Local copy of the sequencer state, all cleared by reset.
    logic [2:0]     st_sys   = SYS_IDLE;
    logic [1:0]     st_batt  = BATT_OK;
    t_pattern       st_pat   = '0;
    logic           st_phase = 1'b0;
    logic [CNT_W-1:0] st_count = '0;
    logic           st_armed = 1'b0;

    // Bookkeeping.
    int fail_count       = 0;
    int words_sent       = 0;
    int results_seen     = 0;
    int settings_written = 0;

    // Supply flags drift slowly so that the battery code stays put for a while.
    logic [2:0] supply_flags = 3'b000;

    // -----------------------------------------------------------------------
    // Model of the sequencer.
    // -----------------------------------------------------------------------

    // The lamp pattern that the current system and battery codes ask for.
    function automatic t_pattern lamps_wanted();
        t_pattern p;
        p = '0;
        p.mode = MODE_OFF;
        if (st_sys != SYS_IDLE) begin
            case (st_sys)
                SYS_BOOT: begin
                    // Without a blue lamp, booting shows yellow instead.
                    if (cf_rgb) begin
                        p.blue = 1'b1;
                    end else begin
                        p.red   = 1'b1;
                        p.green = 1'b1;
                    end
                    p.mode = MODE_NORMAL;
                end
                SYS_JOIN: begin
                    p.red  = 1'b1;
                    p.mode = MODE_NORMAL;
                end
                SYS_SAMPLE: begin
                    p.red   = 1'b1;
                    p.green = 1'b1;
                    p.mode  = MODE_ALT;
                end
                SYS_SEND: begin
                    p.green = 1'b1;
                    p.mode  = MODE_NORMAL;
                end
                SYS_REBOOT: begin
                    p.red  = 1'b1;
                    p.mode = MODE_FAST;
                end
                default: begin
                    p.mode = MODE_OFF;
                end
            endcase
        end else begin
            case (st_batt)
                BATT_LOW: begin
                    p.red  = 1'b1;
                    p.mode = MODE_RARE;
                end
                BATT_CHARGING: begin
                    p.red  = 1'b1;
                    p.mode = MODE_BREATH;
                end
                BATT_CHARGED: begin
                    p.green = 1'b1;
                    p.mode  = MODE_BREATH;
                end
                default: begin
                    p.mode = MODE_OFF;
                end
            endcase
        end
        return p;
    endfunction

    // One update: sample the battery, maybe re-pick, step the phase, reload.
    function automatic void run_lamp_update(input t_in_word w, input logic forced);
        logic             changed;
        logic [1:0]       b;
        t_pattern         p;
        logic [PERIOD_W-1:0] delay;
        changed = 1'b0;
        b = BATT_OK;
        if (cf_batt_en) begin
            if (w.charging) begin
                b = BATT_CHARGING;
            end else if (w.vbus_present) begin
                b = BATT_CHARGED;
            end else if (w.battery_low) begin
                b = BATT_LOW;
            end
        end
        // With sampling on, an unchanged battery code leaves the pattern alone.
        if (!cf_batt_en || b != st_batt) begin
            st_batt = b;
            p = lamps_wanted();
            if (p != st_pat) begin
                st_pat  = p;
                changed = 1'b1;
            end
        end
        changed = changed | forced;
        delay = cf_refresh;
        case (st_pat.mode)
            MODE_OFF: begin
                st_phase = 1'b0;
            end
            MODE_BREATH: begin
                st_phase = 1'b1;
            end
            default: begin
                // A fresh pattern starts lit; otherwise the phase flips.
                st_phase = (changed || !st_phase) ? 1'b1 : 1'b0;
                if (st_pat.mode == MODE_ALT || st_pat.mode == MODE_NORMAL) begin
                    delay = cf_normal;
                end else if (st_pat.mode == MODE_FAST) begin
                    delay = cf_fast;
                end else begin
                    delay = st_phase ? cf_rare_on : cf_rare_off;
                end
            end
        endcase
        // A zero period counts as one tick; a period wider than the counter
        // saturates at its top value.
        if (delay == '0) begin
            st_count = CNT_W'(1);
        end else if (LOAD_W'(delay) > LOAD_W'({CNT_W{1'b1}})) begin
            st_count = '1;
        end else begin
            st_count = CNT_W'(delay);
        end
        st_armed = 1'b1;
    endfunction

    // Step the model by one accepted word and return the lamp word it gives.
    function automatic t_out_word predict_lamps(input t_in_word w);
        t_out_word o;
        t_pattern  p;
        logic      alt;
        if (w.operation == OP_NOTIFY) begin
            // A notify with the same code is ignored; one that keeps the
            // pattern only stores the code.
            if (w.system_state != st_sys) begin
                st_sys = w.system_state;
                p = lamps_wanted();
                if (p != st_pat) begin
                    st_pat = p;
                    run_lamp_update(w, 1'b1);
                end
            end
        end else if (st_armed) begin
            // Ticks do nothing until the first update has armed the timer.
            if (st_count <= CNT_W'(1)) begin
                run_lamp_update(w, 1'b0);
            end else begin
                st_count = st_count - CNT_W'(1);
            end
        end
        alt = (st_pat.mode == MODE_ALT);
        o.red_on          = (st_phase ^ alt) & st_pat.red;
        o.green_on        = st_phase & st_pat.green;
        o.blue_on         = cf_rgb & st_phase & st_pat.blue;
        o.breath_select   = (st_pat.mode == MODE_BREATH);
        o.blink_timer_run = (st_pat.mode >= MODE_NORMAL);
        o.keep_awake      = st_phase | alt;
        return o;
    endfunction

    // Mirror a register write; unknown indexes leave everything as it was.
    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [PERIOD_W-1:0] data);
        case (idx)
            CFG_NORMAL_PERIOD:   cf_normal   = data;
            CFG_FAST_PERIOD:     cf_fast     = data;
            CFG_RARE_ON_PERIOD:  cf_rare_on  = data;
            CFG_RARE_OFF_PERIOD: cf_rare_off = data;
            CFG_REFRESH_PERIOD:  cf_refresh  = data;
            CFG_RGB_VARIANT:     cf_rgb      = data[0];
            CFG_BATTERY_ENABLE:  cf_batt_en  = data[0];
            default: begin
            end
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers.
    // -----------------------------------------------------------------------

    function automatic t_in_word make_word(input logic op, input logic [2:0] sys,
                                           input logic chg, input logic vbus,
                                           input logic low);
        t_in_word w;
        w.operation    = op;
        w.system_state = sys;
        w.charging     = chg;
        w.vbus_present = vbus;
        w.battery_low  = low;
        return w;
    endfunction

    // Mostly ticks with a notify now and then; idle is favored so that the
    // battery table gets plenty of use. Every tenth word or so carries
    // random supply flags as noise.
    function automatic t_in_word random_word();
        t_in_word w;
        if ($urandom_range(0, 19) == 0) begin
            supply_flags = 3'($urandom_range(0, 7));
        end
        w.operation    = ($urandom_range(0, 99) < 22) ? OP_NOTIFY : OP_TICK;
        w.system_state = ($urandom_range(0, 2) == 0) ? SYS_IDLE : 3'($urandom_range(0, 7));
        {w.charging, w.vbus_present, w.battery_low} =
            ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : supply_flags;
        return w;
    endfunction

    // One register write over the configuration channel.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_setting(idx, data);
        i_cfg_valid <= 1'b0;
        settings_written++;
    endtask

    // Wait until every queued word went in and every lamp word came out,
    // then give the pipeline a few more cycles. Bounded so a lost word
    // cannot hang the run here.
    task automatic wait_for_idle();
        int guard;
        guard = 0;
        while ((pending_words.size() != 0 || i_in_valid || expected_lamps.size() != 0)
               && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // -----------------------------------------------------------------------
    // Driver: offers queued words in bursts of random length separated by
    // random gaps. A gap is only opened once the current word has been taken,
    // so valid never drops while a word is waiting.
    // -----------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_lamps.push_back(predict_lamps(i_in_word));
                words_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= pending_words.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // A quarter of the bursts run on without any gap.
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: its ready steps through a set of patterns, from always ready
    // through random and toggling stalls. Twice in the run it holds ready low
    // for a long stretch so that both pipeline registers fill and the input
    // stalls while the driver keeps offering words.
    // -----------------------------------------------------------------------
    int rx_cycle     = 0;
    int rx_hold_left = 0;
    bit rx_hold_done_a = 1'b0;
    bit rx_hold_done_b = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (!rx_hold_done_a && results_seen >= 600) begin
                rx_hold_done_a = 1'b1;
                rx_hold_left   = 150;
            end
            if (!rx_hold_done_b && results_seen >= 1300) begin
                rx_hold_done_b = 1'b1;
                rx_hold_left   = 220;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case ((rx_cycle / 61) % 5)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= ($urandom_range(0, 9) < 7);
                    2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                    3:       i_out_ready <= rx_cycle[0];
                    default: i_out_ready <= ((rx_cycle % 4) != 0);
                endcase
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: every accepted lamp word is compared, bit by bit, with the
    // oldest expectation.
    // -----------------------------------------------------------------------
    string     lamp_field_names[6] = '{"keep_awake", "blink_timer_run", "breath_select",
                                       "blue_on", "green_on", "red_on"};
    t_out_word lamp_wanted;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_lamps.size() == 0) begin
                $error("output word %b arrived with nothing expected", o_out_word);
                fail_count++;
            end else begin
                lamp_wanted = expected_lamps.pop_front();
                for (int i = 0; i < 6; i++) begin
                    if (lamp_wanted[i] !== o_out_word[i]) begin
                        $error("%s: expected %0b, got %0b", lamp_field_names[i],
                               lamp_wanted[i], o_out_word[i]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Test sequence: reset, a directed part, then phases of random words with
    // a new register setting before each one.
    // -----------------------------------------------------------------------
    initial begin
        logic [PERIOD_W-1:0] setting [7];
        int                  n_words;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // At the reset defaults: ticks before any update do nothing, and a
        // notify of the idle code that is already stored is ignored.
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_TICK, 3'd7, 1'b1, 1'b1, 1'b1));
        pending_words.push_back(make_word(OP_NOTIFY, SYS_IDLE, 1'b1, 1'b0, 1'b0));
        wait_for_idle();

        // Short periods so that the directed words reach countdown expiry.
        write_reg(CFG_NORMAL_PERIOD, 16'd2);
        write_reg(CFG_FAST_PERIOD, 16'd1);
        write_reg(CFG_RARE_ON_PERIOD, 16'd1);
        write_reg(CFG_RARE_OFF_PERIOD, 16'd3);
        write_reg(CFG_REFRESH_PERIOD, 16'd2);
        write_reg(CFG_RGB_VARIANT, 16'd1);
        write_reg(CFG_BATTERY_ENABLE, 16'd1);

        // Every system code in turn, the two off codes back to back (the
        // second keeps the pattern), then the idle battery cases.
        pending_words.push_back(make_word(OP_NOTIFY, SYS_BOOT, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_NOTIFY, 3'd6, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_NOTIFY, 3'd7, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_NOTIFY, SYS_SAMPLE, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_NOTIFY, SYS_REBOOT, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_NOTIFY, SYS_JOIN, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_NOTIFY, SYS_SEND, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_NOTIFY, SYS_IDLE, 1'b1, 1'b1, 1'b1));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b1, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b1, 1'b0));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b1, 1'b0));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b0, 1'b1));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b0, 1'b1));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b0, 1'b1));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b0, 1'b0));
        pending_words.push_back(make_word(OP_TICK, SYS_IDLE, 1'b0, 1'b0, 1'b0));
        wait_for_idle();

        for (int ph = 0; ph < 8; ph++) begin
            // Pick this phase's register values: small random periods,
            // zero, one, the maximum, and a mix of very short and very long.
            for (int r = 0; r < 5; r++) begin
                case (ph)
                    2:       setting[r] = 16'd0;
                    3:       setting[r] = 16'd1;
                    4:       setting[r] = 16'hFFFF;
                    5:       setting[r] = (r % 2 == 0) ? 16'($urandom_range(1, 3)) : 16'hFFFF;
                    0, 1:    setting[r] = 16'($urandom_range(1, 5));
                    default: setting[r] = 16'($urandom_range(1, 12));
                endcase
            end
            // The one-bit registers also get random upper data bits.
            setting[CFG_RGB_VARIANT]    = {15'($urandom_range(0, 32767)), 1'b0};
            setting[CFG_BATTERY_ENABLE] = {15'($urandom_range(0, 32767)), 1'b0};
            case (ph)
                0, 4:    setting[CFG_RGB_VARIANT][0] = 1'b1;
                1, 2:    setting[CFG_RGB_VARIANT][0] = 1'b0;
                3:       setting[CFG_RGB_VARIANT][0] = 1'b1;
                default: setting[CFG_RGB_VARIANT][0] = 1'($urandom_range(0, 1));
            endcase
            case (ph)
                0, 2, 4: setting[CFG_BATTERY_ENABLE][0] = 1'b1;
                1, 3:    setting[CFG_BATTERY_ENABLE][0] = 1'b0;
                default: setting[CFG_BATTERY_ENABLE][0] = 1'($urandom_range(0, 1));
            endcase

            for (int r = 0; r < 7; r++) begin
                write_reg(CFG_IDX_W'(r), setting[r]);
            end
            if (ph == 0 || ph == 6) begin
                write_reg(CFG_UNUSED_INDEX, 16'($urandom_range(0, 65535)));
            end

            // With the maximum periods hardly anything expires, so that
            // phase is kept short.
            n_words = (ph == 4) ? 120 : 260;
            for (int k = 0; k < n_words; k++) begin
                pending_words.push_back(random_word());
            end
            wait_for_idle();
        end

        if (expected_lamps.size() != 0) begin
            $error("%0d expected output words never arrived", expected_lamps.size());
            fail_count += expected_lamps.size();
        end
        $display("Covered %0d input words and %0d lamp words checked,", words_sent,
                 results_seen);
        $display("across %0d register writes in nine register settings.", settings_written);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: the whole run needs well under a tenth of this.
    initial begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lps_pkg.sv
src/lps_cfg.sv
src/lps_core.sv
src/status_led_pattern_sequencer_top.sv
test/tb_status_led_pattern_sequencer_top.sv
